// ===== design/psob_pkg.sv =====
// Shared types, constants and codes for the polar scan occupancy binner.
// No dependencies; used by every design module except psob_checker, and by the bench.
`timescale 1ns / 1ps

package psob_pkg;

    // Sizing
    localparam int MAX_BINS    = 32;
    localparam int MAX_SECTORS = 1024;
    localparam int BIN_W       = $clog2(MAX_BINS);        // bin position
    localparam int NB_W        = $clog2(MAX_BINS + 1);    // bin count, holds MAX_BINS
    localparam int SEC_W       = $clog2(MAX_SECTORS);

    // Field widths
    localparam int RANGE_W   = 16;
    localparam int STEP_W    = 12;
    localparam int HALF_W    = STEP_W - 1;
    localparam int CTR_W     = 17;   // bin centre plus window, up to 31 * 4095 + 2047
    localparam int NBREG_W   = 6;
    localparam int RAYREG_W  = 7;
    localparam int RAYCNT_W  = 6;
    localparam int SECOUT_W  = 10;
    localparam int BINOUT_W  = 5;
    localparam int CODE_W    = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int MAX_RAYS  = 64;

    // Cell codes
    localparam logic [CODE_W-1:0] CODE_FREE     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_LETHAL   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_OCCLUDED = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_RMAX  = 2'd1;
    localparam logic [1:0] REG_NBINS = 2'd2;
    localparam logic [1:0] REG_RAYS  = 2'd3;

    // Register reset values
    localparam logic [STEP_W-1:0]   RST_STEP  = 12'd100;
    localparam logic [RANGE_W-1:0]  RST_RMAX  = 16'd30000;
    localparam logic [NBREG_W-1:0]  RST_NBINS = 6'd29;
    localparam logic [RAYREG_W-1:0] RST_RAYS  = 7'd10;

    // Ray wavefront moving along the cell row
    typedef struct packed {
        logic               vld;
        logic [RANGE_W-1:0] d;
        logic [CTR_W-1:0]   c;
    } t_wave;

    // Row-wide control broadcast to every cell
    typedef struct packed {
        logic clr;     // scan start or end of sector output: forget all bins
        logic shift;   // move codes one cell towards bin 0
    } t_cell_ctl;

endpackage

// ===== design/polar_scan_occupancy_binner.sv =====
// Top level of the polar scan occupancy binner: stream ports, APB registers,
// sector control. Depends on psob_pkg and psob_row.
`timescale 1ns / 1ps

// Range readings enter on the s_axis side one item at a time; each ray runs as a
// wavefront along a row of bin cells, one cell per clock, and the input is held
// until the ray reaches the last of the N bins in use (bins_in_use clamped to
// 1..32). When the item closes a sector, the bin codes are shifted out of the
// row nearest first, one result item per clock while m_axis_tready is high;
// the row is left clear for the next sector. The input is taken again once the
// last code of a sector has been loaded into the output register. Registers sit
// at byte addresses 0 (radius step), 4 (range for no-return readings), 8 (bins
// in use) and 12 (rays per sector) and are to be written only while the block
// is idle.

module polar_scan_occupancy_binner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] range_mm
    input  logic [1:0]  s_axis_tuser,   // [0] no_return, [1] scan_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [9:0] sector_index, [14:10] bin_index,
                                        // [16:15] cell_code, [23:17] zero
    output logic        m_axis_tlast,   // last_bin
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RAY,
        S_EMIT
    } t_state;

    // configuration registers
    logic [psob_pkg::STEP_W-1:0]   r_step;
    logic [psob_pkg::RANGE_W-1:0]  r_rmax;
    logic [psob_pkg::NBREG_W-1:0]  r_nbins;
    logic [psob_pkg::RAYREG_W-1:0] r_rays;

    // control state
    t_state                         r_state;
    logic [psob_pkg::BIN_W-1:0]     r_cnt;
    logic [psob_pkg::BIN_W-1:0]     r_bin;
    logic [psob_pkg::RAYCNT_W-1:0]  r_ray;
    logic [psob_pkg::SEC_W-1:0]     r_sector;
    logic                           r_emit;
    logic                           r_tvalid;
    logic [psob_pkg::OUT_TDATA_W-1:0] r_tdata;
    logic                           r_tlast;

    logic                           cfg_wr;
    logic                           accept;
    logic                           start;
    logic                           emit_fire;
    logic                           last_now;
    logic                           complete;
    logic [psob_pkg::RAYCNT_W-1:0]  n_ray;
    logic [psob_pkg::NB_W-1:0]      nb_eff;
    logic [psob_pkg::BIN_W-1:0]     nb_m1;
    logic [psob_pkg::RAYREG_W-1:0]  rays_eff;
    logic [psob_pkg::CODE_W-1:0]    head_code;
    psob_pkg::t_cell_ctl            ctl;
    psob_pkg::t_wave                wave0;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= psob_pkg::RST_STEP;
            r_rmax  <= psob_pkg::RST_RMAX;
            r_nbins <= psob_pkg::RST_NBINS;
            r_rays  <= psob_pkg::RST_RAYS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                psob_pkg::REG_STEP:  r_step  <= pwdata[psob_pkg::STEP_W-1:0];
                psob_pkg::REG_RMAX:  r_rmax  <= pwdata[psob_pkg::RANGE_W-1:0];
                psob_pkg::REG_NBINS: r_nbins <= pwdata[psob_pkg::NBREG_W-1:0];
                psob_pkg::REG_RAYS:  r_rays  <= pwdata[psob_pkg::RAYREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            psob_pkg::REG_STEP:  prdata = 32'(r_step);
            psob_pkg::REG_RMAX:  prdata = 32'(r_rmax);
            psob_pkg::REG_NBINS: prdata = 32'(r_nbins);
            psob_pkg::REG_RAYS:  prdata = 32'(r_rays);
            default:             prdata = '0;
        endcase
    end

    // Clamped counts
    always_comb begin
        if (r_nbins == '0) begin
            nb_eff = psob_pkg::NB_W'(1);
        end else if (psob_pkg::NB_W'(r_nbins) > psob_pkg::NB_W'(psob_pkg::MAX_BINS)) begin
            nb_eff = psob_pkg::NB_W'(psob_pkg::MAX_BINS);
        end else begin
            nb_eff = psob_pkg::NB_W'(r_nbins);
        end
        nb_m1 = psob_pkg::BIN_W'(nb_eff - psob_pkg::NB_W'(1));

        if (r_rays == '0) begin
            rays_eff = psob_pkg::RAYREG_W'(1);
        end else if (r_rays > psob_pkg::RAYREG_W'(psob_pkg::MAX_RAYS)) begin
            rays_eff = psob_pkg::RAYREG_W'(psob_pkg::MAX_RAYS);
        end else begin
            rays_eff = r_rays;
        end
    end

    // Item acceptance and sector bookkeeping
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tuser[1];

    always_comb begin
        n_ray    = (start ? '0 : r_ray) + psob_pkg::RAYCNT_W'(1);
        complete = (n_ray == '0) || (psob_pkg::RAYREG_W'(n_ray) >= rays_eff);
    end

    assign emit_fire = (r_state == S_EMIT) && (!r_tvalid || m_axis_tready);
    assign last_now  = (r_bin == nb_m1);

    // Row drive; a scan start and the last code out of a sector also clear the row
    always_comb begin
        ctl.clr     = (accept && start) || (emit_fire && last_now);
        ctl.shift   = emit_fire;
        wave0.vld   = accept;
        wave0.d     = s_axis_tuser[0] ? r_rmax : s_axis_tdata;
        wave0.c     = '0;
    end

    psob_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nb    (nb_eff),
        .i_step  (r_step),
        .i_ctl   (ctl),
        .i_wave  (wave0),
        .o_code  (head_code)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_bin    <= '0;
            r_ray    <= '0;
            r_sector <= '0;
            r_emit   <= 1'b0;
            r_tvalid <= 1'b0;
            r_tdata  <= '0;
            r_tlast  <= 1'b0;
        end else begin
            // a new code is loaded, or the held one is not yet taken
            r_tvalid <= emit_fire || (r_tvalid && !m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ray  <= complete ? '0 : n_ray;
                        r_emit <= complete;
                        r_bin  <= '0;
                        r_cnt  <= psob_pkg::BIN_W'(1);
                        if (start) begin
                            r_sector <= '0;
                        end
                        if (nb_m1 != '0) begin
                            r_state <= S_RAY;
                        end else if (complete) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_RAY: begin
                    if (r_cnt == nb_m1) begin
                        r_state <= r_emit ? S_EMIT : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + psob_pkg::BIN_W'(1);
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_tdata  <= {7'd0, head_code, psob_pkg::BINOUT_W'(r_bin),
                                     psob_pkg::SECOUT_W'(r_sector)};
                        r_tlast  <= last_now;
                        r_bin    <= r_bin + psob_pkg::BIN_W'(1);
                        if (last_now) begin
                            r_sector <= r_sector + psob_pkg::SEC_W'(1);
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

endmodule

// ===== design/psob_cell.sv =====
// One radial bin cell: holds the bin's decided flag and code, judges the passing
// ray and hands it on with the next centre. Depends on psob_pkg.
`timescale 1ns / 1ps

module psob_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [psob_pkg::BIN_W-1:0]       i_idx,
    input  logic [psob_pkg::NB_W-1:0]        i_nb,
    input  logic [psob_pkg::STEP_W-1:0]      i_step,
    input  psob_pkg::t_cell_ctl              i_ctl,
    input  psob_pkg::t_wave                  i_wave,
    output psob_pkg::t_wave                  o_wave,
    input  logic [psob_pkg::CODE_W-1:0]      i_up_code,
    output logic [psob_pkg::CODE_W-1:0]      o_code
);

    logic                          r_dec;
    logic [psob_pkg::CODE_W-1:0]   r_code;
    psob_pkg::t_wave               r_wave;

    logic                          dec_eff;
    logic [psob_pkg::CTR_W-1:0]    d_ext;
    logic [psob_pkg::CTR_W-1:0]    v_ext;
    logic                          hit_lethal;
    logic                          hit_occl;
    logic                          pass_on;

    // Window tests against this bin's centre
    always_comb begin
        dec_eff    = i_ctl.clr ? 1'b0 : r_dec;
        d_ext      = psob_pkg::CTR_W'(i_wave.d);
        v_ext      = psob_pkg::CTR_W'(i_step >> 1);
        hit_lethal = (d_ext + v_ext > i_wave.c) && (d_ext < i_wave.c + v_ext);
        hit_occl   = (i_wave.c + v_ext >= d_ext);
        // the ray dies at the last bin in use
        pass_on    = i_wave.vld &&
                     (psob_pkg::NB_W'(i_idx) + psob_pkg::NB_W'(1) < i_nb);
    end

    // Bin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec  <= 1'b0;
            r_code <= psob_pkg::CODE_FREE;
        end else if (i_ctl.shift) begin
            // the last shift of a sector also empties the row
            r_dec  <= 1'b0;
            r_code <= i_ctl.clr ? psob_pkg::CODE_FREE : i_up_code;
        end else if (i_wave.vld && !dec_eff && (hit_lethal || hit_occl)) begin
            r_dec  <= 1'b1;
            r_code <= hit_lethal ? psob_pkg::CODE_LETHAL : psob_pkg::CODE_OCCLUDED;
        end else if (i_ctl.clr) begin
            r_dec  <= 1'b0;
            r_code <= psob_pkg::CODE_FREE;
        end
    end

    // Wavefront register towards the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.vld <= 1'b0;
        end else begin
            r_wave.vld <= pass_on;
        end
        r_wave.d <= i_wave.d;
        r_wave.c <= i_wave.c + psob_pkg::CTR_W'(i_step);
    end

    assign o_wave = r_wave;
    assign o_code = r_code;

endmodule

// ===== design/psob_row.sv =====
// Row of bin cells: chains the ray wavefront outwards and the code shift inwards.
// Depends on psob_pkg and psob_cell.
`timescale 1ns / 1ps

module psob_row (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [psob_pkg::NB_W-1:0]        i_nb,
    input  logic [psob_pkg::STEP_W-1:0]      i_step,
    input  psob_pkg::t_cell_ctl              i_ctl,
    input  psob_pkg::t_wave                  i_wave,
    output logic [psob_pkg::CODE_W-1:0]      o_code
);

    psob_pkg::t_wave               wave_in  [psob_pkg::MAX_BINS];
    psob_pkg::t_wave               wave_out [psob_pkg::MAX_BINS];
    logic [psob_pkg::CODE_W-1:0]   code_up  [psob_pkg::MAX_BINS];
    logic [psob_pkg::CODE_W-1:0]   code_out [psob_pkg::MAX_BINS];

    for (genvar k = 0; k < psob_pkg::MAX_BINS; k++) begin : g_cell
        // neighbour links
        if (k == 0) begin : g_head
            assign wave_in[k] = i_wave;
        end else begin : g_link
            assign wave_in[k] = wave_out[k-1];
        end
        if (k == psob_pkg::MAX_BINS - 1) begin : g_tail
            assign code_up[k] = psob_pkg::CODE_FREE;
        end else begin : g_up
            assign code_up[k] = code_out[k+1];
        end

        psob_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (psob_pkg::BIN_W'(k)),
            .i_nb      (i_nb),
            .i_step    (i_step),
            .i_ctl     (i_ctl),
            .i_wave    (wave_in[k]),
            .o_wave    (wave_out[k]),
            .i_up_code (code_up[k]),
            .o_code    (code_out[k])
        );
    end

    assign o_code = code_out[0];

endmodule

// ===== design/psob_checker.sv =====
// Port-level checks for the polar scan occupancy binner, bound to its top level.
// Depends on polar_scan_occupancy_binner's ports only.
`timescale 1ns / 1ps

module psob_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // No new reading is taken while a sector is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a sector");

    // Bins of one sector come out back to back, in order, same sector number
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid &&
            (m_axis_tdata[14:10] == 5'($past(m_axis_tdata[14:10]) + 5'd1)) &&
            (m_axis_tdata[9:0] == $past(m_axis_tdata[9:0])))
        else $error("bin sequence broken within a sector");

    // Cell codes stay in the legal set and the pad bits stay zero
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:15] != 2'd3) && (m_axis_tdata[23:17] == 7'd0))
        else $error("illegal cell code or pad bits");

endmodule

bind polar_scan_occupancy_binner psob_checker u_psob_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for polar_scan_occupancy_binner: directed rays from a table,
// then random scans, with every bin code checked against an in-bench sector predictor.
// Depends on psob_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int DRAIN_CYCLES   = 2 * psob_pkg::MAX_BINS + 16;  // one ray plus one drain
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 290;
    localparam int STRETCH_ITEMS  = 100;

    // One emitted bin code, as carried on the output stream
    typedef struct packed {
        logic [psob_pkg::SECOUT_W-1:0] sector;
        logic [psob_pkg::BINOUT_W-1:0] bin;
        logic [psob_pkg::CODE_W-1:0]   code;
        logic                          last;
    } t_cell;

    // Directed stimulus row: either a register write or a ray
    typedef struct {
        bit                           is_cfg;
        logic [1:0]                   reg_idx;
        logic [31:0]                  value;
        logic [psob_pkg::RANGE_W-1:0] range_mm;
        bit                           no_ret;
        bit                           start;
        bit                           typed;      // codes below given by hand
        logic [psob_pkg::CODE_W-1:0]  code0;      // bin 0
        logic [psob_pkg::CODE_W-1:0]  code_rest;  // every other bin
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and its copy of the registers
    logic [psob_pkg::STEP_W-1:0]   step_mm   = psob_pkg::RST_STEP;
    logic [psob_pkg::RANGE_W-1:0]  rmax_mm   = psob_pkg::RST_RMAX;
    logic [psob_pkg::NBREG_W-1:0]  nbins_reg = psob_pkg::RST_NBINS;
    logic [psob_pkg::RAYREG_W-1:0] rays_reg  = psob_pkg::RST_RAYS;
    bit                            cell_done [psob_pkg::MAX_BINS];
    logic [psob_pkg::CODE_W-1:0]   cell_val  [psob_pkg::MAX_BINS];
    logic [psob_pkg::RAYCNT_W-1:0] ray_cnt    = '0;
    logic [psob_pkg::SEC_W-1:0]    sector_cnt = '0;

    t_cell exp_cells [$];
    t_row  dir_rows  [$];
    int    mismatch_cnt = 0;
    int    idle_cycles  = 0;
    bit    gaps_on      = 1'b1;

    polar_scan_occupancy_binner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sector predictor
    // ------------------------------------------------------------------
    function automatic int unsigned bins_eff();
        if (nbins_reg == 0) return 1;
        if (nbins_reg > psob_pkg::MAX_BINS) return psob_pkg::MAX_BINS;
        return nbins_reg;
    endfunction

    function automatic int unsigned rays_eff();
        if (rays_reg == 0) return 1;
        if (rays_reg > psob_pkg::MAX_RAYS) return psob_pkg::MAX_RAYS;
        return rays_reg;
    endfunction

    function automatic void clear_cells();
        int b;
        for (b = 0; b < psob_pkg::MAX_BINS; b++) begin
            cell_done[b] = 1'b0;
            cell_val[b]  = psob_pkg::CODE_FREE;
        end
    endfunction

    // Apply one ray; queue the sector's codes when it closes the sector
    function automatic void bin_ray(input logic [psob_pkg::RANGE_W-1:0] range_in,
                                    input bit no_ret, input bit start, input bit typed,
                                    input logic [psob_pkg::CODE_W-1:0] code0,
                                    input logic [psob_pkg::CODE_W-1:0] code_rest);
        int unsigned nb, d, v, c;
        int b;
        t_cell res;
        nb = bins_eff();
        if (start) begin
            clear_cells();
            ray_cnt    = '0;
            sector_cnt = '0;
        end
        d = no_ret ? rmax_mm : range_in;
        v = step_mm >> 1;
        for (b = 0; b < nb; b++) begin
            if (!cell_done[b]) begin
                c = b * step_mm;
                if (d + v > c && d < c + v) begin
                    cell_val[b]  = psob_pkg::CODE_LETHAL;
                    cell_done[b] = 1'b1;
                end else if (c + v >= d) begin
                    cell_val[b]  = psob_pkg::CODE_OCCLUDED;
                    cell_done[b] = 1'b1;
                end
            end
        end
        ray_cnt = ray_cnt + 1'b1;
        // a 6-bit wrap to zero also closes the sector
        if (ray_cnt == 0 || ray_cnt >= rays_eff()) begin
            for (b = 0; b < nb; b++) begin
                res.sector = sector_cnt;
                res.bin    = b[psob_pkg::BINOUT_W-1:0];
                res.code   = typed ? ((b == 0) ? code0 : code_rest) : cell_val[b];
                res.last   = (b + 1 == nb);
                exp_cells  = {exp_cells, res};
            end
            clear_cells();
            ray_cnt    = '0;
            sector_cnt = sector_cnt + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_ray(input logic [psob_pkg::RANGE_W-1:0] range_in, input bit no_ret,
                            input bit start, input bit typed,
                            input logic [psob_pkg::CODE_W-1:0] code0,
                            input logic [psob_pkg::CODE_W-1:0] code_rest);
        int unsigned gap;
        gap = (gaps_on && $urandom_range(99) < 7) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= range_in;
        s_axis_tuser  <= {start, no_ret};
        do @(posedge i_clk); while (!s_axis_tready);
        bin_ray(range_in, no_ret, start, typed, code0, code_rest);
    endtask

    // Register write once the block has gone quiet
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (exp_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            psob_pkg::REG_STEP:  step_mm   = val[psob_pkg::STEP_W-1:0];
            psob_pkg::REG_RMAX:  rmax_mm   = val[psob_pkg::RANGE_W-1:0];
            psob_pkg::REG_NBINS: nbins_reg = val[psob_pkg::NBREG_W-1:0];
            psob_pkg::REG_RAYS:  rays_reg  = val[psob_pkg::RAYREG_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly near a bin edge or centre, otherwise anywhere in the field
    function automatic logic [psob_pkg::RANGE_W-1:0] pick_range();
        int c, v, r;
        if ($urandom_range(99) < 65) begin
            v = step_mm >> 1;
            c = $urandom_range(0, bins_eff()) * step_mm;
            r = c + $urandom_range(0, 2 * v + 4) - (v + 2);
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            return r[psob_pkg::RANGE_W-1:0];
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] val);
        t_row row;
        row = '{default: 0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = val;
        dir_rows    = {dir_rows, row};
    endfunction

    function automatic void add_ray(input logic [psob_pkg::RANGE_W-1:0] range_in,
                                    input bit no_ret, input bit start, input bit typed,
                                    input logic [psob_pkg::CODE_W-1:0] code0,
                                    input logic [psob_pkg::CODE_W-1:0] code_rest);
        t_row row;
        row = '{default: 0};
        row.range_mm  = range_in;
        row.no_ret    = no_ret;
        row.start     = start;
        row.typed     = typed;
        row.code0     = code0;
        row.code_rest = code_rest;
        dir_rows      = {dir_rows, row};
    endfunction

    // Receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 7);
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_cnt++;
        $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_cell want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_cells.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, 0);
            end else begin
                want = exp_cells.pop_front();
                if (m_axis_tdata[9:0] != want.sector)
                    report_mismatch("sector_index", m_axis_tdata[9:0], want.sector);
                if (m_axis_tdata[14:10] != want.bin)
                    report_mismatch("bin_index", m_axis_tdata[14:10], want.bin);
                if (m_axis_tdata[16:15] != want.code)
                    report_mismatch("cell_code", m_axis_tdata[16:15], want.code);
                if (m_axis_tlast != want.last)
                    report_mismatch("last_bin", m_axis_tlast, want.last);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int i, n_items, rand_items, sel;
        logic [31:0] v_step, v_rmax, v_bins, v_rays;
        clear_cells();

        // reset values: first ray at zero decides every bin
        add_ray(16'd0, 0, 1, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        for (i = 0; i < 8; i++)
            add_ray(16'd0, 1, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'hFFFF, 1, 0, 1, psob_pkg::CODE_LETHAL, psob_pkg::CODE_OCCLUDED);
        // zero bins and zero rays act as one
        add_cfg(psob_pkg::REG_RAYS, 0);
        add_cfg(psob_pkg::REG_NBINS, 0);
        add_ray(16'd0, 0, 1, 1, psob_pkg::CODE_LETHAL, psob_pkg::CODE_FREE);
        add_ray(16'd50, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        // no-return reading with a zero substitute range; bins saturate
        add_cfg(psob_pkg::REG_RMAX, 0);
        add_cfg(psob_pkg::REG_NBINS, 63);
        add_ray(16'hFFFF, 1, 0, 1, psob_pkg::CODE_LETHAL, psob_pkg::CODE_OCCLUDED);
        add_cfg(psob_pkg::REG_RMAX, 65535);
        add_cfg(psob_pkg::REG_STEP, 4000);
        add_ray(16'hFFFF, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'd0, 1, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        // zero step: every centre at zero
        add_cfg(psob_pkg::REG_STEP, 0);
        add_ray(16'd0, 0, 0, 1, psob_pkg::CODE_OCCLUDED, psob_pkg::CODE_OCCLUDED);
        add_ray(16'd1, 0, 0, 1, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_cfg(psob_pkg::REG_STEP, 1);
        add_ray(16'd3, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_cfg(psob_pkg::REG_STEP, 4095);
        add_ray(16'hFFFF, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        // scan start drops a partial sector
        add_cfg(psob_pkg::REG_STEP, 100);
        add_cfg(psob_pkg::REG_NBINS, 6);
        add_cfg(psob_pkg::REG_RAYS, 10);
        add_ray(16'd120, 0, 1, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'd260, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'd330, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'd0, 0, 1, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'd55, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        add_ray(16'd410, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        // ray count already past the new setting closes the sector
        add_cfg(psob_pkg::REG_RAYS, 2);
        add_ray(16'd149, 0, 0, 0, psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg)
                write_reg(dir_rows[k].reg_idx, dir_rows[k].value);
            else
                send_ray(dir_rows[k].range_mm, dir_rows[k].no_ret, dir_rows[k].start,
                         dir_rows[k].typed, dir_rows[k].code0, dir_rows[k].code_rest);
        end

        // one-ray, one-bin sectors, unbroken, with no idling on either side
        write_reg(psob_pkg::REG_STEP, $urandom_range(3, 300));
        write_reg(psob_pkg::REG_NBINS, 1);
        write_reg(psob_pkg::REG_RAYS, 1);
        gaps_on = 1'b0;
        for (i = 0; i < STRETCH_ITEMS; i++)
            send_ray(pick_range(), $urandom_range(99) < 8, i == 0, 0,
                     psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
        gaps_on = 1'b1;

        // random settings, each phase a scan of random length
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            sel = $urandom_range(15);
            v_step = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 2 : (sel == 3) ? 4095 :
                     (sel == 4) ? $urandom_range(2000, 4000) : $urandom_range(3, 300);
            sel = $urandom_range(15);
            v_bins = (sel == 0) ? 0 : (sel == 1) ? 32 : (sel == 2) ? $urandom_range(33, 63) :
                     $urandom_range(1, 12);
            sel = $urandom_range(19);
            v_rays = (sel == 0) ? 0 : (sel == 1) ? 64 : (sel == 2) ? $urandom_range(65, 127) :
                     (sel <= 5) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            sel = $urandom_range(7);
            v_rmax = (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel <= 4) ?
                     $urandom_range(0, 65535) : $urandom_range(0, 32 * v_step);
            if (v_rmax > 65535) v_rmax = 65535;
            write_reg(psob_pkg::REG_STEP, v_step);
            write_reg(psob_pkg::REG_RMAX, v_rmax);
            write_reg(psob_pkg::REG_NBINS, v_bins);
            write_reg(psob_pkg::REG_RAYS, v_rays);
            n_items = rays_eff() * ((rays_eff() > 16) ? 1 : $urandom_range(2, 6))
                      + $urandom_range(0, 2);
            for (i = 0; i < n_items; i++)
                send_ray(pick_range(), $urandom_range(99) < 8,
                         (i == 0) || ($urandom_range(99) < 3), 0,
                         psob_pkg::CODE_FREE, psob_pkg::CODE_FREE);
            rand_items += n_items;
        end

        // let the last sector drain
        s_axis_tvalid <= 1'b0;
        while (exp_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/psob_pkg.sv
design/psob_cell.sv
design/psob_row.sv
design/polar_scan_occupancy_binner.sv
design/psob_checker.sv
tb/sv/testbench.sv
